// File: hw/rtl/dedup_packet_fifo_with_range_count_top_defines.svh
// Assertion macros for the deduplicating packet FIFO.
`ifndef DEDUP_PACKET_FIFO_WITH_RANGE_COUNT_TOP_DEFINES_SVH
`define DEDUP_PACKET_FIFO_WITH_RANGE_COUNT_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define DPF_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define DPF_ASSERT_NEXT(lbl, trig, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (expr)) \
        else $error(msg);

`else

`define DPF_ASSERT_ALWAYS(lbl, expr, msg)
`define DPF_ASSERT_NEXT(lbl, trig, expr, msg)

`endif

`endif

// File: hw/rtl/dpf_pkg.sv
// Shared types, constants and helpers for the deduplicating packet FIFO.
`timescale 1ns / 1ps
`default_nettype none

package dpf_pkg;

    localparam int DEPTH     = 64;
    localparam int ID_BITS   = 16;
    localparam int TIME_BITS = 32;

    localparam int LIM_W   = 7;
    localparam int RC_W    = 7;
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int CNT_W   = OCC_W;
    localparam int CMP_W   = (OCC_W > LIM_W) ? OCC_W : LIM_W;
    localparam int SAT_W   = (CNT_W > RC_W) ? CNT_W : RC_W;
    localparam int GRP     = 8;
    localparam int NGRP    = (DEPTH + GRP - 1) / GRP;
    localparam int GSUM_W  = $clog2(GRP + 1);
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(64);
    localparam logic [RC_W-1:0]  RC_MAX    = '1;

    localparam logic [1:0] FN_ADD = 2'd0;
    localparam logic [1:0] FN_FWD = 2'd1;
    localparam logic [1:0] FN_CNT = 2'd2;

    localparam logic REG_MEM_LIMIT = 1'b0;

    typedef struct packed {
        logic [1:0]           func;
        logic [ID_BITS-1:0]   source;
        logic [ID_BITS-1:0]   destination;
        logic [TIME_BITS-1:0] timestamp;
        logic [TIME_BITS-1:0] start_time;
        logic [TIME_BITS-1:0] end_time;
    } t_in_word;

    typedef struct packed {
        logic                 added;
        logic                 pkt_valid;
        logic [ID_BITS-1:0]   out_source;
        logic [ID_BITS-1:0]   out_destination;
        logic [TIME_BITS-1:0] out_timestamp;
        logic [RC_W-1:0]      range_count;
    } t_out_word;

    typedef struct packed {
        logic [ID_BITS-1:0]   src;
        logic [ID_BITS-1:0]   dst;
        logic [TIME_BITS-1:0] ts;
    } t_pkt;

    typedef struct packed {
        logic shift;
        logic write;
        logic capture;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_ADD,
        ST_FWD,
        ST_SUM1,
        ST_SUM2,
        ST_FIN
    } t_state;

    // Clamp the programmed limit into 1..DEPTH.
    function automatic logic [OCC_W-1:0] eff_limit(input logic [LIM_W-1:0] lim);
        logic [CMP_W-1:0] l;
        l = CMP_W'(lim);
        if (l == '0) begin
            l = CMP_W'(1);
        end else if (l > CMP_W'(DEPTH)) begin
            l = CMP_W'(DEPTH);
        end
        return OCC_W'(l);
    endfunction

    // Saturate a match count to the result field.
    function automatic logic [RC_W-1:0] sat_count(input logic [CNT_W-1:0] cnt);
        logic [SAT_W-1:0] c;
        c = SAT_W'(cnt);
        if (c > SAT_W'(RC_MAX)) begin
            c = SAT_W'(RC_MAX);
        end
        return RC_W'(c);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dedup_packet_fifo_with_range_count_top.sv
// Top level of the deduplicating packet FIFO with range count.
`timescale 1ns / 1ps
`default_nettype none
`include "dedup_packet_fifo_with_range_count_top_defines.svh"

// Channel   Direction  Handshake                         Word
// in        in         i_in_valid / o_in_ready           t_in_word
// out       out        o_out_valid / i_out_ready         t_out_word
// config    in         psel, penable, pwrite, pready     memory_limit at byte 0
//
// From accept to result loaded, the single sequencer steps the cell row: a
// compare cycle, one head pop per cycle while evicting or forwarding, the
// two-stage match count tree for a count, then the final step; it passes
// through idle before taking the next word.
// Reset (synchronous, active low) empties the row and sets the limit to 64.
// A full output register stalls the sequencer in its final step only.

module dedup_packet_fifo_with_range_count_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input words
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire dpf_pkg::t_in_word           i_in_word,
    // result words
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output dpf_pkg::t_out_word               o_out_word,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dpf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [dpf_pkg::PDATA_W-1:0] pwdata,
    output logic [dpf_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);
    import dpf_pkg::*;

    // Sequencer and datapath registers.
    t_state          r_state, n_state;
    logic [OCC_W-1:0] r_occ, n_occ;
    t_in_word        r_item, n_item;
    t_out_word       r_res, n_res;
    logic            r_out_valid, n_out_valid;
    t_out_word       r_out_word, n_out_word;
    logic [LIM_W-1:0] r_mem_limit;

    // Cell row wiring.
    logic             w_valid [DEPTH];
    t_pkt             w_pkt   [DEPTH];
    logic [DEPTH-1:0] w_valid_vec;
    logic [DEPTH-1:0] w_dup;
    logic [DEPTH-1:0] w_hit;
    logic             w_shift, w_write, w_capture;
    logic [CNT_W-1:0] w_count;
    logic [OCC_W-1:0] w_lim;
    logic             w_cfg_wr;

    assign w_lim = eff_limit(r_mem_limit);

    // ---------------------------------------------------------------
    // Configuration port: one register, always ready.
    // ---------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[PADDR_W-1] == REG_MEM_LIMIT);
    assign prdata   = (paddr[PADDR_W-1] == REG_MEM_LIMIT) ? PDATA_W'(r_mem_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_limit <= LIM_RESET;
        end else if (w_cfg_wr) begin
            r_mem_limit <= pwdata[LIM_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Cell row: cell 0 is the oldest word, live words fill 0..occ-1.
    // A pop shifts every cell one place toward the head; an append
    // writes the cell at index occ.
    // ---------------------------------------------------------------
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_cell_ctl w_ctl;
        logic      w_nv;
        t_pkt      w_np;

        assign w_ctl.shift   = w_shift;
        assign w_ctl.write   = w_write && (r_occ == OCC_W'(i));
        assign w_ctl.capture = w_capture;

        if (i == DEPTH - 1) begin : g_tail
            assign w_nv = 1'b0;
            assign w_np = '0;
        end else begin : g_body
            assign w_nv = w_valid[i+1];
            assign w_np = w_pkt[i+1];
        end

        dpf_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_key        (r_item),
            .i_next_valid (w_nv),
            .i_next_pkt   (w_np),
            .o_valid      (w_valid[i]),
            .o_pkt        (w_pkt[i]),
            .o_dup        (w_dup[i]),
            .o_hit        (w_hit[i])
        );

        assign w_valid_vec[i] = w_valid[i];
    end

    // Count the range hits over two registered stages.
    dpf_popcnt u_popcnt (
        .i_clk   (i_clk),
        .i_flags (w_hit),
        .o_count (w_count)
    );

    // ---------------------------------------------------------------
    // Sequencer.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_item      = r_item;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        w_shift     = 1'b0;
        w_write     = 1'b0;
        w_capture   = 1'b0;
        o_in_ready  = 1'b0;

        // Drop the result once taken.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_item  = i_in_word;
                    n_res   = '0;
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                // Every cell compares against the held word in parallel.
                w_capture = 1'b1;
                unique case (r_item.func)
                    FN_ADD:  n_state = ST_ADD;
                    FN_FWD:  n_state = ST_FWD;
                    FN_CNT:  n_state = ST_SUM1;
                    default: n_state = ST_FIN;
                endcase
            end
            ST_ADD: begin
                if (|w_dup) begin
                    // Reject an exact duplicate.
                    n_state = ST_FIN;
                end else if (r_occ >= w_lim) begin
                    // Evict the oldest word, one per cycle.
                    w_shift = 1'b1;
                    n_occ   = r_occ - OCC_W'(1);
                end else begin
                    w_write     = 1'b1;
                    n_occ       = r_occ + OCC_W'(1);
                    n_res.added = 1'b1;
                    n_state     = ST_FIN;
                end
            end
            ST_FWD: begin
                if (r_occ != '0) begin
                    w_shift               = 1'b1;
                    n_occ                 = r_occ - OCC_W'(1);
                    n_res.pkt_valid       = 1'b1;
                    n_res.out_source      = w_pkt[0].src;
                    n_res.out_destination = w_pkt[0].dst;
                    n_res.out_timestamp   = w_pkt[0].ts;
                end
                n_state = ST_FIN;
            end
            ST_SUM1: begin
                n_state = ST_SUM2;
            end
            ST_SUM2: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                // Hold here until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_res;
                    if (r_item.func == FN_CNT) begin
                        n_out_word.range_count = sat_count(w_count);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // ---------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------
    `DPF_ASSERT_ALWAYS(a_occ_matches_cells, $countones(w_valid_vec) == int'(r_occ), "occupancy differs from live cells")
    `DPF_ASSERT_ALWAYS(a_add_within_limit, !(r_state == ST_FIN && r_res.added) || (r_occ <= w_lim), "add left occupancy above limit")
    `DPF_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready && r_state == ST_CMP, "sequencer did not start after accept")
    `DPF_ASSERT_NEXT(a_result_on_finish, r_state == ST_FIN && (!r_out_valid || i_out_ready), o_out_valid && r_state == ST_IDLE, "result not loaded on finish")

endmodule

`default_nettype wire

// File: hw/rtl/dpf_cell.sv
// One FIFO cell: holds a packet, shifts toward the head, flags key matches.
`timescale 1ns / 1ps
`default_nettype none

module dpf_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dpf_pkg::t_cell_ctl i_ctl,
    input  wire dpf_pkg::t_in_word i_key,
    input  wire logic              i_next_valid,
    input  wire dpf_pkg::t_pkt     i_next_pkt,
    output logic                   o_valid,
    output dpf_pkg::t_pkt          o_pkt,
    output logic                   o_dup,
    output logic                   o_hit
);
    import dpf_pkg::*;

    logic r_valid, n_valid;
    t_pkt r_pkt, n_pkt;
    logic r_dup, r_hit;
    logic w_dup, w_hit;

    always_comb begin
        n_valid = r_valid;
        n_pkt   = r_pkt;
        if (i_ctl.write) begin
            n_valid = 1'b1;
            n_pkt   = '{src: i_key.source, dst: i_key.destination, ts: i_key.timestamp};
        end else if (i_ctl.shift) begin
            n_valid = i_next_valid;
            n_pkt   = i_next_pkt;
        end
    end

    assign w_dup = r_valid && (r_pkt.src == i_key.source) &&
                   (r_pkt.dst == i_key.destination) && (r_pkt.ts == i_key.timestamp);
    assign w_hit = r_valid && (r_pkt.dst == i_key.destination) &&
                   (r_pkt.ts >= i_key.start_time) && (r_pkt.ts <= i_key.end_time);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pkt <= n_pkt;
        if (i_ctl.capture) begin
            r_dup <= w_dup;
            r_hit <= w_hit;
        end
    end

    assign o_valid = r_valid;
    assign o_pkt   = r_pkt;
    assign o_dup   = r_dup;
    assign o_hit   = r_hit;

endmodule

`default_nettype wire

// File: hw/rtl/dpf_popcnt.sv
// Two-stage registered population count over the cell match flags.
`timescale 1ns / 1ps
`default_nettype none

module dpf_popcnt (
    input  wire logic                      i_clk,
    input  wire logic [dpf_pkg::DEPTH-1:0] i_flags,
    output logic [dpf_pkg::CNT_W-1:0]      o_count
);
    import dpf_pkg::*;

    logic [NGRP*GRP-1:0] w_pad;
    logic [GSUM_W-1:0]   n_grp [NGRP];
    logic [GSUM_W-1:0]   r_grp [NGRP];
    logic [CNT_W-1:0]    n_sum, r_sum;

    assign w_pad = (NGRP*GRP)'(i_flags);

    // Stage one: sum each group of eight flags.
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < GRP; k++) begin
                n_grp[g] = n_grp[g] + GSUM_W'(w_pad[g*GRP + k]);
            end
        end
    end

    // Stage two: add the group sums.
    always_comb begin
        n_sum = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_sum = n_sum + CNT_W'(r_grp[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
        r_sum <= n_sum;
    end

    assign o_count = r_sum;

endmodule

`default_nettype wire

// File: tb/sv/dedup_packet_fifo_with_range_count_top_test.sv
// Self-checking testbench for the deduplicating packet FIFO with range count.
`timescale 1ns / 1ps

module dedup_packet_fifo_with_range_count_top_test;
    import dpf_pkg::*;

    // func code that the block must treat as a no-op with an all-zero result
    localparam logic [1:0] FN_UNKNOWN = 2'd3;
    localparam logic [PADDR_W-1:0] MEM_LIMIT_ADDR = PADDR_W'(4 * REG_MEM_LIMIT);
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned RECENT_MAX = 16;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_word i_in_word = '0;

    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_word o_out_word;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    // Mirror of the FIFO contents, kept in step with every accepted word.
    t_pkt held_pkt [DEPTH];
    bit held_valid [DEPTH];
    int unsigned head_slot = 0;
    int unsigned held_count = 0;
    logic [LIM_W-1:0] limit_reg = LIM_RESET;

    // Results still owed by the block, oldest first.
    t_out_word pending_results[$];
    // Recently added packets, replayed to provoke duplicates and count hits.
    t_pkt recent_adds[$];

    int unsigned fail_count = 0;
    bit quiet_mode = 1'b0;
    bit hold_req = 1'b0;
    bit hold_ack = 1'b0;

    dedup_packet_fifo_with_range_count_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #4 i_clk = ~i_clk;

    // Compute the result of one word and advance the mirrored FIFO state.
    function automatic t_out_word fifo_response(input t_in_word w);
        t_out_word r;
        int unsigned cap;
        int unsigned slot;
        int unsigned hits;
        bit dup;
        r = '0;
        dup = 1'b0;
        hits = 0;
        case (w.func)
            FN_ADD: begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (held_valid[i] && held_pkt[i].src == w.source &&
                        held_pkt[i].dst == w.destination && held_pkt[i].ts == w.timestamp)
                        dup = 1'b1;
                end
                if (!dup) begin
                    // a zero limit acts as one, anything above the depth as the depth
                    cap = (limit_reg == 0) ? 1 : ((limit_reg > DEPTH) ? DEPTH : limit_reg);
                    // evict the oldest silently until there is room under the limit
                    while (held_count >= cap) begin
                        held_valid[head_slot] = 1'b0;
                        head_slot = (head_slot + 1) % DEPTH;
                        held_count--;
                    end
                    slot = (head_slot + held_count) % DEPTH;
                    held_pkt[slot] = '{src: w.source, dst: w.destination, ts: w.timestamp};
                    held_valid[slot] = 1'b1;
                    held_count++;
                    r.added = 1'b1;
                end
            end
            FN_FWD: begin
                if (held_count != 0) begin
                    r.pkt_valid = 1'b1;
                    r.out_source = held_pkt[head_slot].src;
                    r.out_destination = held_pkt[head_slot].dst;
                    r.out_timestamp = held_pkt[head_slot].ts;
                    held_valid[head_slot] = 1'b0;
                    head_slot = (head_slot + 1) % DEPTH;
                    held_count--;
                end
            end
            FN_CNT: begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (held_valid[i] && held_pkt[i].dst == w.destination &&
                        held_pkt[i].ts >= w.start_time && held_pkt[i].ts <= w.end_time)
                        hits++;
                end
                r.range_count = (hits > RC_MAX) ? RC_MAX : RC_W'(hits);
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    function automatic t_in_word op_word(input logic [1:0] fn, input logic [ID_BITS-1:0] s,
                                         input logic [ID_BITS-1:0] d,
                                         input logic [TIME_BITS-1:0] ts,
                                         input logic [TIME_BITS-1:0] lo,
                                         input logic [TIME_BITS-1:0] hi);
        t_in_word w;
        w.func = fn;
        w.source = s;
        w.destination = d;
        w.timestamp = ts;
        w.start_time = lo;
        w.end_time = hi;
        return w;
    endfunction

    // Fully random fields; the operation overrides what it uses.
    function automatic t_in_word random_word();
        return op_word(2'($urandom), 16'($urandom), 16'($urandom), $urandom, $urandom,
                       $urandom);
    endfunction

    // Mostly a small pool so that packets collide, sometimes the top or any value.
    function automatic logic [ID_BITS-1:0] pick_id();
        case ($urandom_range(0, 9))
            0: return '1;
            1, 2, 3, 4, 5, 6: return ID_BITS'($urandom_range(0, 3));
            default: return ID_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [TIME_BITS-1:0] pick_time();
        case ($urandom_range(0, 9))
            0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            1, 2, 3, 4, 5, 6: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_word make_add();
        t_in_word w;
        t_pkt p;
        w = random_word();
        w.func = FN_ADD;
        if (recent_adds.size() != 0 && $urandom_range(0, 4) == 0) begin
            p = recent_adds[$urandom_range(0, recent_adds.size() - 1)];
        end else begin
            p.src = pick_id();
            p.dst = pick_id();
            p.ts = pick_time();
        end
        w.source = p.src;
        w.destination = p.dst;
        w.timestamp = p.ts;
        recent_adds = {recent_adds, p};
        if (recent_adds.size() > RECENT_MAX)
            void'(recent_adds.pop_front());
        return w;
    endfunction

    function automatic t_in_word make_count();
        t_in_word w;
        t_pkt p;
        logic [TIME_BITS-1:0] a;
        logic [TIME_BITS-1:0] b;
        w = random_word();
        w.func = FN_CNT;
        a = pick_time();
        b = pick_time();
        if (recent_adds.size() != 0 && $urandom_range(0, 1) == 0) begin
            p = recent_adds[$urandom_range(0, recent_adds.size() - 1)];
            w.destination = p.dst;
        end else begin
            p.ts = a;
            w.destination = pick_id();
        end
        case ($urandom_range(0, 9))
            0: begin
                w.start_time = '0;
                w.end_time = '1;
            end
            1: begin
                // empty range: start above end
                if (a == b)
                    b = a ^ 32'd1;
                w.start_time = (a > b) ? a : b;
                w.end_time = (a > b) ? b : a;
            end
            2: begin
                w.start_time = p.ts;
                w.end_time = p.ts;
            end
            default: begin
                w.start_time = (a < b) ? a : b;
                w.end_time = (a < b) ? b : a;
            end
        endcase
        return w;
    endfunction

    function automatic t_in_word make_item(input int unsigned add_pct);
        t_in_word w;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < add_pct) begin
            w = make_add();
        end else if (roll < add_pct + 22) begin
            w = random_word();
            w.func = FN_FWD;
        end else if (roll < 96) begin
            w = make_count();
        end else begin
            w = random_word();
            w.func = FN_UNKNOWN;
        end
        return w;
    endfunction

    // ---------------------------------------------------------------------
    // Handshake tasks
    // ---------------------------------------------------------------------

    // Offer one word, hold it until accepted, then predict its result.
    // Valid stays high afterwards unless a random gap is taken.
    task automatic send_word(input t_in_word w);
        int unsigned gap;
        t_out_word want;
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        want = fifo_response(w);
        pending_results = {pending_results, want};
        if (!quiet_mode && $urandom_range(0, 99) < 11) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        // let the sequencer settle back to idle
        repeat (4) @(posedge i_clk);
    endtask

    // APB write of the limit register: setup cycle, then access cycle.
    task automatic write_mem_limit(input logic [PDATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MEM_LIMIT_ADDR;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        limit_reg = value[LIM_W-1:0];
    endtask

    // ---------------------------------------------------------------------
    // Result sink: random stalls, plus a long hold-off on request
    // ---------------------------------------------------------------------
    initial begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            // a toggled request starts one long hold-off, counted here
            if (hold_left == 0 && hold_req != hold_ack) begin
                hold_left = HOLD_CYCLES;
                hold_ack <= hold_req;
            end
            if (hold_left != 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= quiet_mode || ($urandom_range(0, 99) >= 11);
            end
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compare every accepted result with the oldest prediction, field by field.
    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word: expected none, actual %h", $time,
                         o_out_word);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("added", want.added, o_out_word.added);
                compare_field("pkt_valid", want.pkt_valid, o_out_word.pkt_valid);
                compare_field("out_source", want.out_source, o_out_word.out_source);
                compare_field("out_destination", want.out_destination,
                              o_out_word.out_destination);
                compare_field("out_timestamp", want.out_timestamp, o_out_word.out_timestamp);
                compare_field("range_count", want.range_count, o_out_word.range_count);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Every operation at the field extremes, with the limit left at reset.
    task automatic test_operations();
        // forward on an empty FIFO returns an all-zero packet
        send_word(op_word(FN_FWD, '1, '1, '1, '1, '1));
        send_word(op_word(FN_ADD, '0, '0, '0, '1, '1));
        send_word(op_word(FN_ADD, '1, '1, '1, '0, '0));
        // exact duplicate of a held packet: reject
        send_word(op_word(FN_ADD, '0, '0, '0, '0, '0));
        // differs only in timestamp: store
        send_word(op_word(FN_ADD, '0, '0, 32'd1, '0, '0));
        send_word(op_word(FN_CNT, '1, '0, '1, '0, '1));
        // empty range, start above end
        send_word(op_word(FN_CNT, '0, '0, '0, 32'd1, '0));
        send_word(op_word(FN_CNT, '0, '1, '0, '1, '1));
        // unknown func: no effect, zero result
        send_word(op_word(FN_UNKNOWN, '1, '1, '1, '1, '1));
        send_word(op_word(FN_FWD, '0, '0, '0, '0, '0));
        send_word(op_word(FN_FWD, '0, '0, '0, '0, '0));
        send_word(op_word(FN_FWD, '0, '0, '0, '0, '0));
        send_word(op_word(FN_FWD, '0, '0, '0, '0, '0));
        drain_results();
    endtask

    // Zero limit, limit above depth, and a limit lowered below occupancy.
    task automatic test_limit_cases();
        // upper bits set, low seven bits zero: acts as a limit of one
        write_mem_limit(32'hFFFF_FF80);
        send_word(op_word(FN_ADD, 16'd1, 16'd2, 32'd3, '0, '0));
        send_word(op_word(FN_ADD, 16'd4, 16'd5, 32'd6, '0, '0));
        send_word(op_word(FN_FWD, '0, '0, '0, '0, '0));
        send_word(op_word(FN_FWD, '0, '0, '0, '0, '0));
        drain_results();
        // all seven bits set: acts as the depth
        write_mem_limit(32'h0000_007F);
        for (int i = 0; i < 5; i++)
            send_word(op_word(FN_ADD, 16'(i), 16'd7, 32'(10 + i), '0, '0));
        drain_results();
        // next add evicts down to the new limit
        write_mem_limit(32'd3);
        send_word(op_word(FN_ADD, 16'd9, 16'd7, 32'd15, '0, '0));
        send_word(op_word(FN_CNT, '0, 16'd7, '0, '0, '1));
        drain_results();
    endtask

    // Stall the result side for a long stretch while words keep coming,
    // so the block fills and holds off its input.
    task automatic test_output_backpressure();
        quiet_mode <= 1'b1;
        hold_req <= ~hold_req;
        for (int i = 0; i < 40; i++)
            send_word(make_item(50));
        quiet_mode <= 1'b0;
        drain_results();
    endtask

    // Random traffic in phases, each under its own limit setting.
    task automatic run_phase(input logic [PDATA_W-1:0] limit_word, input int unsigned count,
                             input int unsigned add_pct, input bit with_quiet);
        write_mem_limit(limit_word);
        for (int i = 0; i < count; i++) begin
            // hold a long stretch with no idling on either side
            if (with_quiet && i == count / 4)
                quiet_mode <= 1'b1;
            if (with_quiet && i == count / 2)
                quiet_mode <= 1'b0;
            send_word(make_item(add_pct));
        end
        // pause until every result is back before the next setting
        drain_results();
    endtask

    task automatic test_random_traffic();
        // add-heavy under the full depth so the store fills up
        run_phase(32'd64, 260, 65, 1'b0);
        // drop to one while full: the first add evicts everything else
        run_phase(32'd1, 180, 45, 1'b0);
        run_phase({25'($urandom), 7'($urandom_range(4, 63))}, 200, 50, 1'b1);
        run_phase(32'hFFFF_FF80, 150, 45, 1'b0);
        run_phase(32'd127, 250, 60, 1'b0);
        run_phase({25'($urandom), 7'($urandom_range(2, 8))}, 300, 50, 1'b0);
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        for (int i = 0; i < DEPTH; i++)
            held_valid[i] = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_operations();
        test_limit_cases();
        test_output_backpressure();
        test_random_traffic();

        // drain already done by the last phase; allow the longest add to finish
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("dedup_packet_fifo_with_range_count_top test passed");
        else
            $display("dedup_packet_fifo_with_range_count_top test failed");
        $finish;
    end

    // Stop a hung run.
    initial begin : watchdog
        #5_000_000;
        $display("dedup_packet_fifo_with_range_count_top test failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/dpf_pkg.sv
hw/rtl/dpf_cell.sv
hw/rtl/dpf_popcnt.sv
hw/rtl/dedup_packet_fifo_with_range_count_top.sv
tb/sv/dedup_packet_fifo_with_range_count_top_test.sv
